// ----- rtl/apd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the arithmetic progression detector.
// No dependencies; every other file imports this package.
package apd_pkg;

   localparam int SAMPLE_BITS    = 64;
   localparam int TOLERANCE_BITS = 32;
   localparam int ETYPE_BITS     = 3;
   localparam int OUT_COUNT_BITS = 32;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ELEMENT_TYPE = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOLERANCE    = 1'd1;

   // Element type codes: bit 0 set means unsigned, bits 2:1 pick the width
   localparam logic [ETYPE_BITS-1:0] ETYPE_S64 = 3'd6;

   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;
   localparam logic [1:0] WIDTH_64 = 2'd3;

   localparam logic [63:0] SMAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMIN64 = 64'h8000_0000_0000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_CHECK,
      ST_SPAN,
      ST_DIV_LOAD,
      ST_DIV,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic load_sample;  // capture the accepted item
      logic calc_diff;    // subtractor: new sample minus previous
      logic check;        // update sequence state with the new difference
      logic calc_span;    // subtractor: last sample minus first
      logic div_load;     // start the step division
      logic div_step;     // one quotient bit
      logic load_out;     // fill the result register and clear the sequence
   } ctrl_cmd_type;

   typedef struct packed {
      logic last;         // held item closes the sequence
      logic regular;      // at least two samples and all changes in tolerance
      logic div_done;     // the current division step is the final one
   } ctrl_status_type;

   function automatic logic elem_signed(input logic [ETYPE_BITS-1:0] etype);
      return !etype[0];
   endfunction

   function automatic logic [63:0] elem_mask(input logic [ETYPE_BITS-1:0] etype);
      logic [63:0] m;
      case (etype[2:1])
         WIDTH_8:  m = 64'h0000_0000_0000_00FF;
         WIDTH_16: m = 64'h0000_0000_0000_FFFF;
         WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
         default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

   // Sign or zero extension of the low element bits to a full word
   function automatic logic [63:0] extend_sample(input logic [63:0] raw,
                                                 input logic [ETYPE_BITS-1:0] etype);
      logic       s;
      logic [63:0] v;
      s = elem_signed(etype);
      case (etype[2:1])
         WIDTH_8:  v = {{56{s & raw[7]}}, raw[7:0]};
         WIDTH_16: v = {{48{s & raw[15]}}, raw[15:0]};
         WIDTH_32: v = {{32{s & raw[31]}}, raw[31:0]};
         default:  v = raw;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/apd_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sample items and result items.
// Depends on apd_pkg.
interface apd_req_if import apd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_bits;
   logic                   last_sample;

   modport source (output valid, output sample_bits, output last_sample, input ready);
   modport sink   (input valid, input sample_bits, input last_sample, output ready);
endinterface

interface apd_rsp_if import apd_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          regular;
   logic [SAMPLE_BITS-1:0]        start_value;
   logic signed [SAMPLE_BITS-1:0] step;
   logic [OUT_COUNT_BITS-1:0]     sample_count;

   modport source (output valid, output regular, output start_value, output step,
                   output sample_count, input ready);
   modport sink   (input valid, input regular, input start_value, input step,
                   input sample_count, output ready);
endinterface

// ----- rtl/apd_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the detector: handshakes, per-item steps, division loop.
// Depends on apd_pkg.
module apd_ctrl import apd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_sample = 1'b1;
               state_in        = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.calc_diff = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = status.last ? ST_SPAN : ST_IDLE;
         end
         ST_SPAN: begin
            cmd.calc_span = 1'b1;
            state_in      = status.regular ? ST_DIV_LOAD : ST_OUT;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_out)     rsp_valid_in = 1'b1;
      else if (rsp_ready)   rsp_valid_in = 1'b0;
      else                  rsp_valid_in = rsp_valid_ff;
   end

   a_accept_starts_diff: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_DIFF)
      else $error("accepted item did not start the difference step");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while still held");

   a_div_follows_load: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load |=> cmd.div_step)
      else $error("division did not start after load");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load_out))
      else $error("result valid raised without a result load");

endmodule

// ----- rtl/apd_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: config registers, sequence state, shared subtractor,
// restoring divider for the mean step, result register. Depends on apd_pkg.
module apd_datapath import apd_pkg::*; #(
   parameter int COUNT_BITS     = 32,
   parameter int STEP_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data,
   input  logic [SAMPLE_BITS-1:0]    req_sample_bits,
   input  logic                      req_last_sample,
   input  ctrl_cmd_type              cmd,
   output ctrl_status_type           status,
   output logic                      rsp_regular,
   output logic [SAMPLE_BITS-1:0]    rsp_start_value,
   output logic [SAMPLE_BITS-1:0]    rsp_step,
   output logic [OUT_COUNT_BITS-1:0] rsp_sample_count
);

   localparam int DVD_BITS  = SAMPLE_BITS + STEP_FRAC_BITS;
   localparam int ITER_BITS = $clog2(DVD_BITS);

   // config
   logic [ETYPE_BITS-1:0]     etype_ff;
   logic [TOLERANCE_BITS-1:0] tol_ff;

   // sequence state
   logic [63:0]           sample_ff;
   logic                  last_ff;
   logic [63:0]           first_ff;
   logic [63:0]           prev_ff;
   logic [63:0]           pdiff_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic                  still_ff;

   // subtractor
   logic [63:0] op_a, op_b;
   logic        sgn;
   logic [65:0] diff_in, diff_ff;
   logic [63:0] d_sat;

   // change check
   logic [64:0] ch_fwd, ch_rev, ch_mag;
   logic        exceed;

   // divider
   logic [63:0]           span_mag;
   logic                  neg_ff;
   logic [DVD_BITS-1:0]   dvd_ff;
   logic [COUNT_BITS-1:0] rem_ff;
   logic [COUNT_BITS-1:0] divisor;
   logic [COUNT_BITS:0]   rem_sh, rem_sub;
   logic                  ge;
   logic [63:0]           q_ff;
   logic                  ovf_ff;
   logic [ITER_BITS-1:0]  it_ff;
   logic [63:0]           step_val;
   logic [OUT_COUNT_BITS-1:0] count_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         etype_ff <= ETYPE_S64;
         tol_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ELEMENT_TYPE: etype_ff <= csr_wr_data[ETYPE_BITS-1:0];
            CSR_TOLERANCE:    tol_ff   <= csr_wr_data[TOLERANCE_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign sgn  = elem_signed(etype_ff);
   assign op_a = cmd.calc_span ? prev_ff  : sample_ff;
   assign op_b = cmd.calc_span ? first_ff : prev_ff;

   // exact difference of two 66-bit extended words
   assign diff_in = {{2{sgn & op_a[63]}}, op_a} - {{2{sgn & op_b[63]}}, op_b};

   always_comb begin
      if (diff_ff[65:63] == 3'b000 || diff_ff[65:63] == 3'b111) d_sat = diff_ff[63:0];
      else if (diff_ff[65])                                     d_sat = SMIN64;
      else                                                      d_sat = SMAX64;
   end

   assign ch_fwd = {d_sat[63], d_sat} - {pdiff_ff[63], pdiff_ff};
   assign ch_rev = {pdiff_ff[63], pdiff_ff} - {d_sat[63], d_sat};
   assign ch_mag = ch_fwd[64] ? ch_rev : ch_fwd;
   assign exceed = ch_mag > {{(65-TOLERANCE_BITS){1'b0}}, tol_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         sample_ff <= extend_sample(req_sample_bits, etype_ff);
         last_ff   <= req_last_sample;
      end
      if (cmd.calc_diff || cmd.calc_span) diff_ff <= diff_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         still_ff <= 1'b1;
         first_ff <= '0;
         prev_ff  <= '0;
         pdiff_ff <= '0;
      end else if (cmd.load_out) begin
         count_ff <= '0;
         still_ff <= 1'b1;
         first_ff <= '0;
         prev_ff  <= '0;
         pdiff_ff <= '0;
      end else if (cmd.check) begin
         if (count_ff == '0) begin
            first_ff <= sample_ff;
            pdiff_ff <= '0;
            still_ff <= 1'b1;
         end else begin
            pdiff_ff <= d_sat;
            if (count_ff >= COUNT_BITS'(2) && exceed) still_ff <= 1'b0;
         end
         prev_ff <= sample_ff;
         if (count_ff != '1) count_ff <= count_ff + COUNT_BITS'(1);
      end
   end

   // divider: (|span| << frac) / (count - 1), one quotient bit per cycle
   assign span_mag = diff_ff[65] ? (64'd0 - diff_ff[63:0]) : diff_ff[63:0];
   assign divisor  = count_ff - COUNT_BITS'(1);
   assign rem_sh   = {rem_ff, dvd_ff[DVD_BITS-1]};
   assign ge       = rem_sh >= {1'b0, divisor};
   assign rem_sub  = rem_sh - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         neg_ff <= diff_ff[65];
         dvd_ff <= DVD_BITS'(span_mag) << STEP_FRAC_BITS;
         rem_ff <= '0;
         q_ff   <= '0;
         ovf_ff <= 1'b0;
         it_ff  <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= ge ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
         q_ff   <= {q_ff[62:0], ge};
         ovf_ff <= ovf_ff | q_ff[63];
         it_ff  <= it_ff + ITER_BITS'(1);
      end
   end

   always_comb begin
      if (ovf_ff || q_ff[63]) step_val = neg_ff ? SMIN64 : SMAX64;
      else if (neg_ff)        step_val = 64'd0 - q_ff;
      else                    step_val = q_ff;
   end

   generate
      if (COUNT_BITS > OUT_COUNT_BITS) begin : g_count_sat
         assign count_sat = (|count_ff[COUNT_BITS-1:OUT_COUNT_BITS]) ? '1
                                                                     : count_ff[OUT_COUNT_BITS-1:0];
      end else begin : g_count_ext
         assign count_sat = OUT_COUNT_BITS'(count_ff);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_regular      <= status.regular;
         rsp_start_value  <= first_ff & elem_mask(etype_ff);
         rsp_step         <= status.regular ? step_val : '0;
         rsp_sample_count <= count_sat;
      end
   end

   assign status.last     = last_ff;
   assign status.regular  = still_ff && count_ff >= COUNT_BITS'(2);
   assign status.div_done = it_ff == ITER_BITS'(DVD_BITS - 1);

endmodule

// ----- rtl/arithmetic_progression_detector.sv -----
`timescale 1ns / 1ps
// Top level of the arithmetic progression detector.
// Depends on apd_pkg, apd_if, apd_ctrl and apd_datapath.

// Takes one sample item at a time and decides whether the sequence closed by
// the item marked last_sample is an arithmetic progression within the
// tolerance register. Samples are read as s8/u8/s16/u16/s32/u32/s64/u64 per
// element_type. An item that does not close a sequence occupies the block for
// the accept, difference and check steps. The closing item adds a step for the
// first-to-last span, then, when the sequence is regular, a load step and a
// radix-2 restoring divider that develops 64 + STEP_FRAC_BITS quotient bits
// (80 at the default), then a step to move the result into the output register.
// A closing item that is not regular skips the load and divider. The output register holds the finished
// item while the next sequence is taken in; only a second result waits for it.
// Configuration writes are taken in any cycle but must only happen while idle.
module arithmetic_progression_detector import apd_pkg::*; #(
   parameter int COUNT_BITS     = 32,
   parameter int STEP_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data,
   apd_req_if.sink                   req_chan,
   apd_rsp_if.source                 rsp_chan
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic [SAMPLE_BITS-1:0] step_bits;

   // sequencer: handshakes and step order
   apd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, sequence state and result register
   apd_datapath #(
      .COUNT_BITS     (COUNT_BITS),
      .STEP_FRAC_BITS (STEP_FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_sample_bits  (req_chan.sample_bits),
      .req_last_sample  (req_chan.last_sample),
      .cmd              (cmd),
      .status           (status),
      .rsp_regular      (rsp_chan.regular),
      .rsp_start_value  (rsp_chan.start_value),
      .rsp_step         (step_bits),
      .rsp_sample_count (rsp_chan.sample_count)
   );

   // step leaves as a signed fixed-point word
   assign rsp_chan.step = $signed(step_bits);

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for arithmetic_progression_detector: directed sequences
// per element type and corner case, then random traffic under varying backpressure.
// Depends on apd_pkg, apd_if and the detector RTL.
module testbench import apd_pkg::*; ();

   localparam int STEP_FRAC     = 16;
   localparam int CYCLE_LIMIT   = 1_000_000;
   // An item that does not close a sequence keeps the block busy through its difference
   // and check steps and gives no result, so let those finish before a register write.
   localparam int SETTLE_CYCLES = 8;

   typedef enum logic [ETYPE_BITS-1:0] {
      ET_S8, ET_U8, ET_S16, ET_U16, ET_S32, ET_U32, ET_S64, ET_U64
   } elem_code_type;

   typedef struct {
      logic        regular;
      logic [63:0] start_value;
      logic [63:0] step;
      logic [31:0] sample_count;
   } summary_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data;

   apd_req_if req_chan ();
   apd_rsp_if rsp_chan ();

   arithmetic_progression_detector i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   // Predictor copy of the registers and of the open sequence
   logic [ETYPE_BITS-1:0]     cfg_etype;
   logic [TOLERANCE_BITS-1:0] cfg_tolerance;
   logic [63:0]               seq_first;
   logic [63:0]               seq_prev;
   logic [63:0]               seq_prev_gap;
   logic [31:0]               seq_count;
   logic                      seq_regular;

   summary_type pending_summaries[$];

   int errors        = 0;
   int items_sent    = 0;
   int cycles        = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL arithmetic_progression_detector");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [63:0] width_mask(input logic [ETYPE_BITS-1:0] et);
      int w;
      w = 8 << et[2:1];
      return (w == 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << w) - 64'd1);
   endfunction

   // Low element bits, sign or zero extended to a word
   function automatic logic [63:0] widen(input logic [63:0] raw,
                                         input logic [ETYPE_BITS-1:0] et);
      logic [63:0] m;
      logic [63:0] v;
      int          w;
      m = width_mask(et);
      w = 8 << et[2:1];
      v = raw & m;
      if (!et[0] && w < 64 && v[w-1]) v = v | ~m;
      return v;
   endfunction

   // Exact a - b, operands read as signed or unsigned words
   function automatic logic signed [65:0] signed_gap(input logic [63:0] a, b,
                                                     input logic sgn);
      logic signed [65:0] ea;
      logic signed [65:0] eb;
      ea = sgn ? {{2{a[63]}}, a} : {2'b00, a};
      eb = sgn ? {{2{b[63]}}, b} : {2'b00, b};
      return ea - eb;
   endfunction

   function automatic logic [63:0] clamp64(input logic signed [65:0] x);
      if (x > $signed({2'b00, SMAX64})) return SMAX64;
      if (x < $signed({2'b11, SMIN64})) return SMIN64;
      return x[63:0];
   endfunction

   // (to - from) / (count - 1) with STEP_FRAC fraction bits, truncated, saturated
   function automatic logic [63:0] mean_step(input logic [63:0] from_v, to_v,
                                             input logic sgn, input logic [31:0] count);
      logic signed [65:0]    span;
      logic [63:0]           mag;
      logic [63+STEP_FRAC:0] divisor;
      logic [63+STEP_FRAC:0] quot;
      span    = signed_gap(to_v, from_v, sgn);
      mag     = (span < 0) ? 64'(-span) : 64'(span);
      divisor = {{(32+STEP_FRAC){1'b0}}, 32'(count - 32'd1)};
      quot    = {mag, {STEP_FRAC{1'b0}}} / divisor;
      if (span < 0) return (|quot[63+STEP_FRAC:63]) ? SMIN64 : -quot[63:0];
      return (|quot[63+STEP_FRAC:63]) ? SMAX64 : quot[63:0];
   endfunction

   function automatic void clear_sequence();
      seq_first    = '0;
      seq_prev     = '0;
      seq_prev_gap = '0;
      seq_count    = '0;
      seq_regular  = 1'b1;
   endfunction

   // Advance the sequence by one accepted item; a closing item queues its summary
   task automatic track_sample(input logic [63:0] raw, input logic last);
      logic [63:0]        v;
      logic [63:0]        gap;
      logic signed [65:0] change;
      summary_type        s;
      v = widen(raw, cfg_etype);
      if (seq_count == 0) begin
         seq_first    = v;
         seq_prev_gap = '0;
         seq_regular  = 1'b1;
      end else begin
         // stored words keep the extension they had when they came in
         gap = clamp64(signed_gap(v, seq_prev, !cfg_etype[0]));
         if (seq_count >= 2) begin
            change = signed_gap(gap, seq_prev_gap, 1'b1);
            if (change < 0) change = -change;
            if (change > $signed({34'b0, cfg_tolerance})) seq_regular = 1'b0;
         end
         seq_prev_gap = gap;
      end
      seq_prev = v;
      if (seq_count != 32'hFFFF_FFFF) seq_count++;
      if (last) begin
         s.regular      = seq_regular && seq_count >= 2;
         s.start_value  = seq_first & width_mask(cfg_etype);
         s.step         = s.regular ? mean_step(seq_first, seq_prev, !cfg_etype[0], seq_count)
                                    : 64'd0;
         s.sample_count = seq_count;
         pending_summaries.push_back(s);
         clear_sequence();
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [63:0] want, got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // Result side: compare each accepted item, then pick ready for the next edge
   always @(posedge clock) begin : result_check
      summary_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_summaries.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %b %h %h %0d", $time,
                     rsp_chan.regular, rsp_chan.start_value, rsp_chan.step,
                     rsp_chan.sample_count);
            errors++;
         end else begin
            want = pending_summaries.pop_front();
            check_field("regular", 64'(want.regular), 64'(rsp_chan.regular));
            check_field("start_value", want.start_value, rsp_chan.start_value);
            check_field("step", want.step, rsp_chan.step);
            check_field("sample_count", 64'(want.sample_count), 64'(rsp_chan.sample_count));
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // ---------------------------------------------------------------- stimulus

   // Offer one item, with random idle cycles ahead of it, and wait until taken
   task automatic send_sample(input logic [63:0] raw, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.sample_bits <= raw;
      req_chan.last_sample <= last;
      do @(posedge clock); while (!req_chan.ready);
      track_sample(raw, last);
      items_sent++;
   endtask

   // Stop sending and let the block drain completely
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_summaries.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers, back to back, only once the block is idle.
   // Upper bits of the element type write are junk the block must ignore.
   task automatic set_config(input logic [ETYPE_BITS-1:0] et,
                             input logic [TOLERANCE_BITS-1:0] tol);
      settle();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_ELEMENT_TYPE;
      csr_wr_data <= {29'($urandom), et};
      @(posedge clock);
      csr_index   <= CSR_TOLERANCE;
      csr_wr_data <= tol;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg_etype     = et;
      cfg_tolerance = tol;
   endtask

   // Mostly a progression with jitter sized to the tolerance; sometimes pure noise
   task automatic send_sequence();
      int              len;
      logic            noisy;
      int unsigned     cap;
      longint unsigned jcap;
      logic [63:0]     base;
      logic [63:0]     stride;
      logic [63:0]     jit;
      logic [63:0]     mask;
      logic [63:0]     value;
      len   = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      noisy = ($urandom_range(3) == 0);
      mask  = width_mask(cfg_etype);
      case (cfg_etype[2:1])
         WIDTH_8:  cap = 4;
         WIDTH_16: cap = 300;
         WIDTH_32: cap = 100000;
         default:  cap = 1 << 30;
      endcase
      stride = 64'($urandom_range(cap));
      if ($urandom_range(1)) stride = -stride;
      jcap = 64'(cfg_tolerance >> 2);
      if (jcap > 64'(cap)) jcap = 64'(cap);
      if ($urandom_range(3) == 0) jcap = 0;
      base = {$urandom, $urandom};
      for (int k = 0; k < len; k++) begin
         jit = 64'($urandom_range(32'(jcap)));
         if ($urandom_range(1)) jit = -jit;
         value = base + 64'(k) * stride + jit;
         // junk above the element width must not matter
         value = (value & mask) | ({$urandom, $urandom} & ~mask);
         if (noisy) value = {$urandom, $urandom};
         send_sample(value, k == len - 1);
      end
   endtask

   // ---------------------------------------------------------------- tests

   // Reset configuration (s64, exact), one lone sample: never regular
   task automatic test_single_sample();
      send_sample({$urandom, $urandom}, 1'b1);
   endtask

   // Each element type with its extreme values; the 64-bit ones saturate the step
   task automatic test_element_types();
      logic [63:0] mask;
      for (int t = int'(ET_S8); t <= int'(ET_U64); t++) begin
         set_config(t[2:0], 32'd0);
         mask = width_mask(t[2:0]);
         if (!t[0]) begin
            send_sample((mask >> 1) | ({$urandom, $urandom} & ~mask), 1'b0);
            send_sample(((mask >> 1) + 64'd1) | ({$urandom, $urandom} & ~mask), 1'b1);
         end else begin
            send_sample({$urandom, $urandom} & ~mask, 1'b0);
            send_sample(mask | ({$urandom, $urandom} & ~mask), 1'b1);
         end
      end
   endtask

   // One off-by-one gap under exact tolerance; the sequence must stay irregular
   task automatic test_sticky_irregular();
      set_config(ET_S32, 32'd0);
      send_sample(64'd0, 1'b0);
      send_sample(64'd10, 1'b0);
      send_sample(64'd21, 1'b0);
      send_sample(64'd31, 1'b0);
      send_sample(64'd41, 1'b1);
   endtask

   // Switch s16 to u16 while a sequence is open
   task automatic test_type_change_mid_sequence();
      set_config(ET_S16, 32'd0);
      send_sample(64'h0000_0000_0000_FFFF, 1'b0);
      send_sample(64'h0000_0000_0000_FFFE, 1'b0);
      set_config(ET_U16, 32'd0);
      send_sample(64'h0000_0000_0000_FFFD, 1'b1);
   endtask

   // Groups of sequences, each group under a fresh random configuration
   task automatic run_traffic(input int n_items, input int send_pct, input int rsp_pct);
      int                        goal;
      logic [TOLERANCE_BITS-1:0] tol;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      goal          = items_sent + n_items;
      while (items_sent < goal) begin
         case ($urandom_range(9))
            0, 1, 2: tol = '0;
            3:       tol = '1;
            4, 5, 6: tol = $urandom_range(16);
            default: tol = $urandom;
         endcase
         set_config(3'($urandom_range(7)), tol);
         repeat ($urandom_range(8, 3)) send_sequence();
      end
   endtask

   initial begin
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_index            <= CSR_ELEMENT_TYPE;
      csr_wr_data          <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.sample_bits <= '0;
      req_chan.last_sample <= 1'b0;
      cfg_etype             = ETYPE_S64;
      cfg_tolerance         = '0;
      clear_sequence();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_sample();
      test_element_types();
      test_sticky_irregular();
      test_type_change_mid_sequence();
      run_traffic(570, 12, 51);
      run_traffic(570, 51, 12);
      run_traffic(570, 0, 0);

      settle();
      repeat (16) @(posedge clock);
      if (errors == 0)
         $display("PASS arithmetic_progression_detector");
      else
         $display("FAIL arithmetic_progression_detector");
      $finish;
   end

endmodule
